/* src/ute_pkg.sv */
// Shared types, constants and tables for the UTC calendar to epoch seconds block.
// Used by every module under src; depends on nothing.
package ute_pkg;

    // Field widths
    localparam int YearW   = 13;
    localparam int MonW    = 4;
    localparam int DayW    = 5;
    localparam int HourW   = 5;
    localparam int MinW    = 6;
    localparam int SecW    = 6;
    localparam int YdayW   = 9;
    localparam int TodW    = 17;
    localparam int DaysW   = 24;
    localparam int ProdW   = 40;
    localparam int EpochW  = 39;
    localparam int InDataW  = 40;
    localparam int OutDataW = 40;

    // Field limits
    localparam logic [MonW-1:0]  MonthMax  = 4'd11;
    localparam logic [HourW-1:0] HourMax   = 5'd23;
    localparam logic [MinW-1:0]  MinuteMax = 6'd59;
    localparam logic [SecW-1:0]  SecondMax = 6'd60;

    // Year offsets of the POSIX formula (years counted from 1900)
    localparam logic [YearW-1:0] YearQuadBase = 13'd69;
    localparam logic [13:0]      YearEraBias  = 14'd299;
    localparam logic signed [13:0] YearEpoch  = 14'sd70;

    // Reciprocal of 100 and 400: x/100 = (x*5243)>>19, x/400 = (x*5243)>>21,
    // exact for x below 43690
    localparam logic [12:0] Recip    = 13'd5243;
    localparam int          Shift100 = 19;
    localparam int          Shift400 = 21;

    localparam logic [13:0] Century   = 14'd100;
    localparam logic [TodW-1:0] SecPerHour = 17'd3600;
    localparam logic [TodW-1:0] SecPerMin  = 17'd60;
    localparam logic signed [DaysW-1:0] DaysPerYear = 24'sd365;
    localparam logic signed [ProdW-1:0] SecPerDay   = 40'sd86400;

    // Front end to day-count stage
    typedef struct packed {
        logic              invalid;
        logic [YearW-1:0]  year;
        logic [YdayW-1:0]  yday;
        logic signed [11:0] quad;
        logic [6:0]        cent;
        logic [5:0]        era;
        logic [TodW-1:0]   tod;
    } ute_front_t;

    // Day-count stage to seconds stage
    typedef struct packed {
        logic                    invalid;
        logic signed [DaysW-1:0] days;
        logic [TodW-1:0]         tod;
    } ute_days_t;

    // Days before the first of a month, normal or leap year
    function automatic logic [YdayW-1:0] days_before(input logic [MonW-1:0] mon,
                                                     input logic leap);
        logic [YdayW-1:0] base;
        base = '0;
        case (mon)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && mon >= 4'd2)
            base = base + 9'd1;
        return base;
    endfunction

endpackage

/* src/ute_front.sv */
// Front end: field check, reciprocal products and leap-year day offset.
// Two register stages; depends on ute_pkg.
module ute_front
    import ute_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [InDataW-1:0]  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ute_front_t          out_item
);

    // Stage A registers
    logic                a_valid_reg;
    logic                a_invalid_reg;
    logic [YearW-1:0]    a_year_reg;
    logic [MonW-1:0]     a_mon_reg;
    logic [DayW-1:0]     a_day_reg;
    logic [TodW-1:0]     a_tod_reg;
    logic [25:0]         a_pm1_reg;
    logic [25:0]         a_p0_reg;
    logic [26:0]         a_p400_reg;

    // Stage B registers
    logic                b_valid_reg;
    ute_front_t          b_item_reg;

    logic                adv_a;
    logic                adv_b;

    logic [YearW-1:0]    y_in;
    logic [MonW-1:0]     mon_in;
    logic [DayW-1:0]     day_in;
    logic [HourW-1:0]    hr_in;
    logic [MinW-1:0]     mn_in;
    logic [SecW-1:0]     sc_in;
    logic [YearW-1:0]    ym1;
    logic [13:0]         yp299;
    logic                invalid_next;
    logic [TodW-1:0]     tod_next;
    logic [25:0]         pm1_next;
    logic [25:0]         p0_next;
    logic [26:0]         p400_next;

    logic [6:0]          q100;
    logic [13:0]         hund;
    logic                leap;
    logic [YearW-1:0]    dlt;
    logic signed [11:0]  qmag;
    ute_front_t          b_item_next;

    assign adv_b    = !b_valid_reg || out_ready;
    assign adv_a    = !a_valid_reg || adv_b;
    assign in_ready = adv_a;

    // Unpack the item and check the fields
    assign y_in   = in_data[12:0];
    assign mon_in = in_data[16:13];
    assign day_in = in_data[21:17];
    assign hr_in  = in_data[26:22];
    assign mn_in  = in_data[32:27];
    assign sc_in  = in_data[38:33];

    always_comb
    begin
        invalid_next = (mon_in > MonthMax) || (day_in == '0) || (hr_in > HourMax)
                    || (mn_in > MinuteMax) || (sc_in > SecondMax);
        tod_next = TodW'(hr_in) * SecPerHour + TodW'(mn_in) * SecPerMin + TodW'(sc_in);
        ym1      = (y_in == '0) ? '0 : y_in - 13'd1;
        yp299    = 14'(y_in) + YearEraBias;
        pm1_next  = 26'(ym1) * 26'(Recip);
        p0_next   = 26'(y_in) * 26'(Recip);
        p400_next = 27'(yp299) * 27'(Recip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv_a)
            a_valid_reg <= in_valid;
    end

    // Hold stage A payload unless it advances
    always_ff @(posedge clk)
    begin
        if (adv_a && in_valid)
        begin
            a_invalid_reg <= invalid_next;
            a_year_reg    <= y_in;
            a_mon_reg     <= mon_in;
            a_day_reg     <= day_in;
            a_tod_reg     <= tod_next;
            a_pm1_reg     <= pm1_next;
            a_p0_reg      <= p0_next;
            a_p400_reg    <= p400_next;
        end
    end

    // Quotients, leap rule and day of year
    always_comb
    begin
        q100 = a_p0_reg[25:Shift100];
        hund = 14'(q100) * Century;
        // A century year is leap only when (year + 1900) is a multiple of 400
        leap = (a_year_reg[1:0] == 2'b00)
            && ((hund != 14'(a_year_reg)) || (q100[1:0] == 2'b01));

        // (year - 69) / 4, truncated toward zero
        if (a_year_reg >= YearQuadBase)
            dlt = a_year_reg - YearQuadBase;
        else
            dlt = YearQuadBase - a_year_reg;
        qmag = $signed({1'b0, dlt[12:2]});

        b_item_next.invalid = a_invalid_reg;
        b_item_next.year    = a_year_reg;
        b_item_next.yday    = days_before(a_mon_reg, leap) + YdayW'(a_day_reg) - 9'd1;
        b_item_next.quad    = (a_year_reg >= YearQuadBase) ? qmag : -qmag;
        b_item_next.cent    = a_pm1_reg[25:Shift100];
        b_item_next.era     = a_p400_reg[26:Shift400];
        b_item_next.tod     = a_tod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv_b)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv_b && a_valid_reg)
            b_item_reg <= b_item_next;
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule

/* src/ute_days.sv */
// Day-count stage: days since the epoch from year, day of year and leap corrections.
// One register stage; depends on ute_pkg.
module ute_days
    import ute_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ute_front_t  in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output ute_days_t   out_item
);

    logic                    valid_reg;
    ute_days_t               item_reg;
    ute_days_t               item_next;
    logic                    adv;
    logic signed [13:0]      yrel;
    logic signed [DaysW-1:0] yterm;

    assign adv      = !valid_reg || out_ready;
    assign in_ready = adv;

    // Sum the year term and the leap-day corrections
    always_comb
    begin
        yrel  = $signed({1'b0, in_item.year}) - YearEpoch;
        yterm = DaysW'(yrel) * DaysPerYear;
        item_next.invalid = in_item.invalid;
        item_next.tod     = in_item.tod;
        item_next.days    = yterm
                          + $signed({15'b0, in_item.yday})
                          + DaysW'(in_item.quad)
                          - $signed({17'b0, in_item.cent})
                          + $signed({18'b0, in_item.era});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* src/ute_secs.sv */
// Seconds stage: days times 86400, plus time of day, into the output register.
// Two register stages; depends on ute_pkg.
module ute_secs
    import ute_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ute_days_t          in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [EpochW-1:0]  epoch,
    output logic               invalid
);

    // Product stage
    logic                    p_valid_reg;
    logic signed [ProdW-1:0] p_prod_reg;
    logic [TodW-1:0]         p_tod_reg;
    logic                    p_invalid_reg;

    // Output register
    logic                    o_valid_reg;
    logic [EpochW-1:0]       o_epoch_reg;
    logic                    o_invalid_reg;

    logic                    adv_p;
    logic                    adv_o;
    logic signed [ProdW-1:0] prod_next;
    logic signed [ProdW-1:0] sum;
    logic [EpochW-1:0]       epoch_next;

    assign adv_o    = !o_valid_reg || out_ready;
    assign adv_p    = !p_valid_reg || adv_o;
    assign in_ready = adv_p;

    assign prod_next = ProdW'(in_item.days) * SecPerDay;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (adv_p)
            p_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv_p && in_valid)
        begin
            p_prod_reg    <= prod_next;
            p_tod_reg     <= in_item.tod;
            p_invalid_reg <= in_item.invalid;
        end
    end

    // Add time of day; force all ones on a bad field
    always_comb
    begin
        sum        = p_prod_reg + $signed({23'b0, p_tod_reg});
        epoch_next = p_invalid_reg ? '1 : sum[EpochW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (adv_o)
            o_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv_o && p_valid_reg)
        begin
            o_epoch_reg   <= epoch_next;
            o_invalid_reg <= p_invalid_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign epoch     = o_epoch_reg;
    assign invalid   = o_invalid_reg;

endmodule

/* src/utc_calendar_to_epoch_seconds.sv */
// UTC calendar to epoch seconds, five-stage pipeline.
// Throughput: one item per cycle while m_tready holds no stage back; the stages,
// in order: check and reciprocal products, leap and day of year, day count,
// days times 86400, final add into the output register.
// Reset (rst_n low, asynchronous) clears all stage valid bits; payload is not reset.
module utc_calendar_to_epoch_seconds
    import ute_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // year_since_1900[12:0], month_index[16:13], day_of_month[21:17],
    // hour_of_day[26:22], minute_of_hour[32:27], second_of_minute[38:33], zero[39]
    input  logic [InDataW-1:0]   s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // epoch_seconds[38:0] (signed), zero[39]
    output logic [OutDataW-1:0]  m_tdata,
    // invalid_fields[0]
    output logic                 m_tuser
);

    logic               front_valid;
    logic               front_ready;
    ute_front_t         front_item;
    logic               days_valid;
    logic               days_ready;
    ute_days_t          days_item;
    logic [EpochW-1:0]  epoch;

    ute_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    ute_days u_days (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (days_valid),
        .out_ready (days_ready),
        .out_item  (days_item)
    );

    ute_secs u_secs (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (days_valid),
        .in_ready  (days_ready),
        .in_item   (days_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .epoch     (epoch),
        .invalid   (m_tuser)
    );

    assign m_tdata = {1'b0, epoch};

endmodule
